// File: hdl/nthp_pkg.sv
package nthp_pkg;

	// field widths
	localparam int START_W = 20;
	localparam int STEP_W  = 10;
	localparam int RANK_W  = 8;
	localparam int PRIME_W = 20;

	localparam int VALUE_BITS_DEF = 20;

	typedef enum logic [2:0] {
		S_IDLE,
		S_GCD,
		S_GCD_WAIT,
		S_TEST,
		S_TRIAL,
		S_TRIAL_WAIT,
		S_NEXT,
		S_FINISH
	} nthp_state_t;

	// request to the shared remainder unit
	typedef struct packed {
		logic start;
		logic use_gcd;
	} nthp_rem_ctl_t;

endpackage

// File: hdl/nthp_rem.sv
// Restoring remainder unit, one quotient bit per cycle.
module nthp_rem import nthp_pkg::*; #(
	parameter int W = VALUE_BITS_DEF
) (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         start,
	input  logic [W-1:0] dividend,
	input  logic [W-1:0] divisor,
	output logic         done,
	output logic [W-1:0] remainder
);

	localparam int CW = $clog2(W + 1);

	logic [CW-1:0] cnt_q;
	logic          done_q;
	logic [W-1:0]  dvd_q;
	logic [W-1:0]  div_q;
	logic [W-1:0]  rem_q;
	logic [W:0]    trial;
	logic [W:0]    diff;
	logic          fits;

	assign trial = {rem_q, dvd_q[W-1]};
	assign diff  = trial - {1'b0, div_q};
	assign fits  = trial >= {1'b0, div_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q  <= '0;
			done_q <= 1'b0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				cnt_q <= CW'(W);
			end else if (cnt_q != '0) begin
				cnt_q <= cnt_q - CW'(1);
				if (cnt_q == CW'(1)) begin
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			dvd_q <= dividend;
			div_q <= divisor;
			rem_q <= '0;
		end else if (cnt_q != '0) begin
			dvd_q <= {dvd_q[W-2:0], 1'b0};
			// remainder stays below divisor, so the top bit drops
			rem_q <= fits ? diff[W-1:0] : trial[W-1:0];
		end
	end

	assign done      = done_q;
	assign remainder = rem_q;

endmodule

// File: hdl/nth_prime_in_arith_progression.sv
// Returns the rank-th prime among the terms start_value, start_value+step, ...
// Each term is tested by trial division with odd divisors 3, 5, 7, ... while the
// divisor squared does not exceed the term; 2 counts as prime, 0 and 1 do not.
// Before the walk, gcd(start_value, step) is taken: when it exceeds 1 (or step
// is 0) only start_value itself can qualify. The search ends with found = 0 and
// prime_value = 0 when rank is 0, when start_value does not fit VALUE_BITS, or
// when the next term would exceed 2^VALUE_BITS - 1. Every remainder (Euclid
// steps and trial divisions) goes through one restoring remainder unit of width
// W = max(VALUE_BITS, 10), so the time per item grows with the gcd steps plus,
// over the tested odd terms, the divisors tried: short for small or even terms,
// long for a high rank over a sparse progression. That remainder unit sets the
// rate. One item is worked at a time; in_ready is low from the accept until the
// result is placed in the output register, and a new item is taken while that
// result still waits for out_ready.
module nth_prime_in_arith_progression import nthp_pkg::*; #(
	parameter int VALUE_BITS = VALUE_BITS_DEF
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	output logic               in_ready,
	input  logic [START_W-1:0] start_value,
	input  logic [STEP_W-1:0]  step,
	input  logic [RANK_W-1:0]  rank,
	output logic               out_valid,
	input  logic               out_ready,
	output logic [PRIME_W-1:0] prime_value,
	output logic               found
);

	localparam int VB = VALUE_BITS;
	// term carries headroom so term + step never wraps
	localparam int TW = VB + STEP_W + 1;
	// remainder unit must also hold step during the gcd
	localparam int W  = (VB > STEP_W) ? VB : STEP_W;
	localparam int SW = VB + 2;

	nthp_state_t state_q, state_d;

	logic [TW-1:0]     term_q;
	logic [STEP_W-1:0] d_q;
	logic [RANK_W-1:0] n_q;
	logic [RANK_W-1:0] seen_q;
	logic              single_q;
	logic [W-1:0]      p_q;
	logic [W-1:0]      q_q;
	logic [VB-1:0]     k_q;
	logic [SW-1:0]     sq_q;
	logic [VB-1:0]     fin_val_q;
	logic              fin_found_q;

	logic               out_valid_q;
	logic [PRIME_W-1:0] out_val_q;
	logic               out_found_q;

	// remainder unit hookup
	nthp_rem_ctl_t rem_ctl;
	logic [W-1:0]  rem_dvd;
	logic [W-1:0]  rem_div;
	logic          rem_done;
	logic [W-1:0]  rem_val;

	// term decode
	logic [VB-1:0] x;
	logic          term_ovf;
	logic          x_lt2;
	logic          x_two;
	logic          sq_gt;
	logic          hit;
	logic          a_ovf;
	logic          accept;
	logic          out_free;

	// control decisions
	logic term_prime;
	logic is_comp;

	assign x        = term_q[VB-1:0];
	assign term_ovf = term_q[TW-1:VB] != '0;
	assign x_lt2    = x < VB'(2);
	assign x_two    = x == VB'(2);
	assign sq_gt    = sq_q > SW'(x);
	assign hit      = (seen_q + RANK_W'(1)) == n_q;
	assign a_ovf    = (32'(start_value) >> VB) != 32'd0;
	assign accept   = in_valid && in_ready;
	assign out_free = !out_valid_q || out_ready;

	assign rem_dvd = rem_ctl.use_gcd ? p_q : W'(x);
	assign rem_div = rem_ctl.use_gcd ? q_q : W'(k_q);

	nthp_rem #(
		.W(W)
	) u_rem (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (rem_ctl.start),
		.dividend (rem_dvd),
		.divisor  (rem_div),
		.done     (rem_done),
		.remainder(rem_val)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// sequencer
	always_comb begin
		state_d         = state_q;
		in_ready        = 1'b0;
		rem_ctl.start   = 1'b0;
		rem_ctl.use_gcd = 1'b0;
		term_prime      = 1'b0;
		is_comp         = 1'b0;
		unique case (state_q)
			S_IDLE: begin
				in_ready = 1'b1;
				if (in_valid) begin
					if (rank == '0 || a_ovf) begin
						state_d = S_FINISH;
					end else if (step == '0) begin
						state_d = S_TEST;
					end else begin
						state_d = S_GCD;
					end
				end
			end
			S_GCD: begin
				rem_ctl.use_gcd = 1'b1;
				if (q_q == '0) begin
					state_d = S_TEST;
				end else begin
					rem_ctl.start = 1'b1;
					state_d       = S_GCD_WAIT;
				end
			end
			S_GCD_WAIT: begin
				rem_ctl.use_gcd = 1'b1;
				if (rem_done) begin
					state_d = S_GCD;
				end
			end
			S_TEST: begin
				if (term_ovf) begin
					state_d = S_FINISH;
				end else if (x_lt2 || (!x_two && !x[0])) begin
					is_comp = 1'b1;
				end else if (x_two) begin
					term_prime = 1'b1;
				end else begin
					state_d = S_TRIAL;
				end
			end
			S_TRIAL: begin
				if (sq_gt) begin
					term_prime = 1'b1;
				end else begin
					rem_ctl.start = 1'b1;
					state_d       = S_TRIAL_WAIT;
				end
			end
			S_TRIAL_WAIT: begin
				if (rem_done) begin
					if (rem_val == '0) begin
						is_comp = 1'b1;
					end else begin
						state_d = S_TRIAL;
					end
				end
			end
			S_NEXT: begin
				state_d = S_TEST;
			end
			S_FINISH: begin
				if (out_free) begin
					state_d = S_IDLE;
				end
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
		// outcome of one term
		if (term_prime) begin
			state_d = (hit || single_q) ? S_FINISH : S_NEXT;
		end else if (is_comp) begin
			state_d = single_q ? S_FINISH : S_NEXT;
		end
	end

	// datapath
	always_ff @(posedge clk) begin
		case (state_q)
			S_IDLE: begin
				term_q      <= TW'(start_value);
				d_q         <= step;
				n_q         <= rank;
				seen_q      <= '0;
				single_q    <= (step == '0);
				p_q         <= W'(start_value);
				q_q         <= W'(step);
				fin_val_q   <= '0;
				fin_found_q <= 1'b0;
			end
			S_GCD: begin
				// gcd above 1: only the first term can qualify
				if (q_q == '0) begin
					single_q <= p_q > W'(1);
				end
			end
			S_GCD_WAIT: begin
				if (rem_done) begin
					p_q <= q_q;
					q_q <= rem_val;
				end
			end
			S_TEST: begin
				k_q  <= VB'(3);
				sq_q <= SW'(9);
			end
			S_TRIAL_WAIT: begin
				if (rem_done) begin
					// (k+2)^2 = k^2 + 4k + 4
					k_q  <= k_q + VB'(2);
					sq_q <= sq_q + {k_q, 2'b00} + SW'(4);
				end
			end
			S_NEXT: begin
				term_q <= term_q + TW'(d_q);
			end
			default: begin
			end
		endcase
		if (term_prime) begin
			seen_q <= seen_q + RANK_W'(1);
			if (hit) begin
				fin_val_q   <= x;
				fin_found_q <= 1'b1;
			end
		end
	end

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (state_q == S_FINISH && out_free) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == S_FINISH && out_free) begin
			out_val_q   <= PRIME_W'(fin_val_q);
			out_found_q <= fin_found_q;
		end
	end

	assign out_valid   = out_valid_q;
	assign prime_value = out_val_q;
	assign found       = out_found_q;

endmodule

// File: hdl/nthp_chk.sv
module nthp_chk import nthp_pkg::*; (
	input logic               clk,
	input logic               arst_n,
	input logic               in_valid,
	input logic               in_ready,
	input logic [START_W-1:0] start_value,
	input logic [STEP_W-1:0]  step,
	input logic [RANK_W-1:0]  rank,
	input logic               out_valid,
	input logic               out_ready,
	input logic [PRIME_W-1:0] prime_value,
	input logic               found
);

	// a miss always reports zero
	a_miss_zero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !found |-> prime_value == '0)
		else $error("not-found beat with nonzero prime_value");

	// a hit is 2 or odd
	a_hit_odd: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && found |-> (prime_value[0] || prime_value == PRIME_W'(2)))
		else $error("found beat with even value other than 2");

	// busy right after an accepted beat
	a_busy: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready |=> !in_ready)
		else $error("in_ready high the cycle after an accept");

	// result held while stalled
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(prime_value) && $stable(found))
		else $error("output beat changed while stalled");

endmodule

bind nth_prime_in_arith_progression nthp_chk u_nthp_chk (.*);
